// File: hdl/tun_pkg.sv
// tun_pkg: shared widths, types and bounds for the triangle unit normal pipeline
// depends on nothing; imported by every module under hdl
package tun_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int OUT_WIDTH        = 16;

  // edge, cross product, magnitude, square, sum and remainder widths
  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int LO_W    = MAG_W / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int REM_W   = SUM_W + 1;

  // quotient floor(c^2 * 2^(2F+2) / s) and its integer square root
  localparam int QUO_W     = 2 * NORMAL_FRAC_BITS + 3;
  localparam int ROOT_W    = (QUO_W + 1) / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;

  localparam logic [QUO_W-1:0]  QUO_MAX  = QUO_W'(1) << (QUO_W - 1);
  localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1) << (ROOT_W - 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_WIDTH-1:0]   normal_t;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_ctl_t;

endpackage

// File: hdl/tun_front.sv
// tun_front: edges, cross product, squared components and their sum (six stages)
// depends on tun_pkg
module tun_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  tun_pkg::coord_t             pa [3],
  input  tun_pkg::coord_t             pb [3],
  input  tun_pkg::coord_t             pc [3],
  output tun_pkg::tun_ctl_t           ctl_out,
  output logic [tun_pkg::SQ_W-1:0]    sq_out [3],
  output logic [tun_pkg::SUM_W-1:0]   sum_out
);
  import tun_pkg::*;

  // stage 1: edges
  logic                     v1;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  // stage 2: products
  logic                     v2;
  logic signed [PROD_W-1:0] pt [3];
  logic signed [PROD_W-1:0] pu [3];
  // stage 3: cross product magnitude and sign
  logic                     v3;
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               neg3;
  // stage 4: partial squares
  logic                     v4;
  logic [2:0]               neg4;
  logic [2*HI_W-1:0]        hh [3];
  logic [HI_W+LO_W-1:0]     hl [3];
  logic [2*LO_W-1:0]        ll [3];
  // stage 5: squares
  logic                     v5;
  logic [2:0]               neg5;
  logic [SQ_W-1:0]          sq [3];
  // stage 6: sum
  tun_ctl_t                 ctl6;
  logic [SQ_W-1:0]          sq6 [3];
  logic [SUM_W-1:0]         sum6;

  logic signed [CROSS_W-1:0] cr [3];
  logic [CROSS_W-1:0]        cabs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]   = CROSS_W'(pt[i]) - CROSS_W'(pu[i]);
      cabs[i] = cr[i][CROSS_W-1] ? CROSS_W'(-cr[i]) : CROSS_W'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ctl6.valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      ctl6.valid <= v5;
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] <= EDGE_W'(pb[i]) - EDGE_W'(pa[i]);
      e2[i] <= EDGE_W'(pc[i]) - EDGE_W'(pa[i]);
    end
    pt[0] <= e1[1] * e2[2];
    pu[0] <= e2[1] * e1[2];
    pt[1] <= e2[0] * e1[2];
    pu[1] <= e1[0] * e2[2];
    pt[2] <= e1[0] * e2[1];
    pu[2] <= e2[0] * e1[1];
    for (int i = 0; i < 3; i++) begin
      mag[i]  <= cabs[i][MAG_W-1:0];
      neg3[i] <= cr[i][CROSS_W-1];
      hh[i]   <= mag[i][MAG_W-1:LO_W] * mag[i][MAG_W-1:LO_W];
      hl[i]   <= mag[i][MAG_W-1:LO_W] * mag[i][LO_W-1:0];
      ll[i]   <= mag[i][LO_W-1:0] * mag[i][LO_W-1:0];
      sq[i]   <= (SQ_W'(hh[i]) << (2 * LO_W)) + (SQ_W'(hl[i]) << (LO_W + 1)) + SQ_W'(ll[i]);
      sq6[i]  <= sq[i];
    end
    neg4 <= neg3;
    neg5 <= neg4;
    ctl6.neg   <= neg5;
    ctl6.degen <= ~(|sq[0] | |sq[1] | |sq[2]);
    sum6 <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  assign ctl_out = ctl6;
  assign sq_out  = sq6;
  assign sum_out = sum6;

endmodule

// File: hdl/tun_div.sv
// tun_div: pipelined restoring divider, one quotient bit per stage, three lanes
// depends on tun_pkg
module tun_div (
  input  logic                        clk,
  input  logic                        rst,
  input  tun_pkg::tun_ctl_t           ctl_in,
  input  logic [tun_pkg::SQ_W-1:0]    sq_in [3],
  input  logic [tun_pkg::SUM_W-1:0]   sum_in,
  output tun_pkg::tun_ctl_t           ctl_out,
  output logic [tun_pkg::QUO_W-1:0]   quo_out [3]
);
  import tun_pkg::*;

  tun_ctl_t         ctl      [QUO_W];
  logic [SUM_W-1:0] dvs      [QUO_W];
  logic [REM_W-1:0] rem      [QUO_W][3];
  logic [QUO_W-1:0] quo      [QUO_W][3];
  logic [REM_W-1:0] rem_next [QUO_W][3];
  logic [QUO_W-1:0] quo_next [QUO_W][3];

  always_comb begin
    logic [REM_W-1:0] src_rem;
    logic [QUO_W-1:0] src_quo;
    logic [REM_W-1:0] src_dvs;
    logic             ge;
    logic [REM_W-1:0] diff;
    for (int k = 0; k < QUO_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          src_rem = REM_W'(sq_in[i]);
          src_quo = '0;
          src_dvs = REM_W'(sum_in);
        end else begin
          src_rem = rem[k-1][i];
          src_quo = quo[k-1][i];
          src_dvs = REM_W'(dvs[k-1]);
        end
        ge   = (src_rem >= src_dvs);
        diff = ge ? (src_rem - src_dvs) : src_rem;
        rem_next[k][i] = diff << 1;
        quo_next[k][i] = {src_quo[QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        ctl[k].degen <= ctl_in.degen;
        ctl[k].neg   <= ctl_in.neg;
        dvs[k]       <= sum_in;
      end else begin
        ctl[k].degen <= ctl[k-1].degen;
        ctl[k].neg   <= ctl[k-1].neg;
        dvs[k]       <= dvs[k-1];
      end
      if (rst) begin
        ctl[k].valid <= 1'b0;
      end else if (k == 0) begin
        ctl[k].valid <= ctl_in.valid;
      end else begin
        ctl[k].valid <= ctl[k-1].valid;
      end
      for (int i = 0; i < 3; i++) begin
        rem[k][i] <= rem_next[k][i];
        quo[k][i] <= quo_next[k][i];
      end
    end
  end

  assign ctl_out = ctl[QUO_W-1];
  always_comb begin
    for (int i = 0; i < 3; i++) quo_out[i] = quo[QUO_W-1][i];
  end

  // a component never exceeds the length, so the scaled ratio stays in range
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid && !ctl_out.degen |->
      quo_out[0] <= QUO_MAX && quo_out[1] <= QUO_MAX && quo_out[2] <= QUO_MAX)
    else $error("quotient above unit scale");

endmodule

// File: hdl/tun_sqrt.sv
// tun_sqrt: pipelined digit-by-digit integer square root, one root bit per stage
// depends on tun_pkg
module tun_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  tun_pkg::tun_ctl_t            ctl_in,
  input  logic [tun_pkg::QUO_W-1:0]    quo_in [3],
  output tun_pkg::tun_ctl_t            ctl_out,
  output logic [tun_pkg::ROOT_W-1:0]   root_out [3]
);
  import tun_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;

  tun_ctl_t            ctl       [ROOT_W];
  logic [RAD_W-1:0]    rad       [ROOT_W][3];
  logic [SQ_REM_W-1:0] rem       [ROOT_W][3];
  logic [ROOT_W-1:0]   root      [ROOT_W][3];
  logic [RAD_W-1:0]    rad_next  [ROOT_W][3];
  logic [SQ_REM_W-1:0] rem_next  [ROOT_W][3];
  logic [ROOT_W-1:0]   root_next [ROOT_W][3];

  always_comb begin
    logic [RAD_W-1:0]    src_rad;
    logic [SQ_REM_W-1:0] src_rem;
    logic [ROOT_W-1:0]   src_root;
    logic [SQ_REM_W-1:0] rem_t;
    logic [SQ_REM_W-1:0] trial;
    logic                ge;
    for (int k = 0; k < ROOT_W; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          src_rad  = RAD_W'(quo_in[i]);
          src_rem  = '0;
          src_root = '0;
        end else begin
          src_rad  = rad[k-1][i];
          src_rem  = rem[k-1][i];
          src_root = root[k-1][i];
        end
        rem_t = {src_rem[SQ_REM_W-3:0], src_rad[RAD_W-1:RAD_W-2]};
        trial = {src_root, 2'b01};
        ge    = (rem_t >= trial);
        rad_next[k][i]  = src_rad << 2;
        rem_next[k][i]  = ge ? (rem_t - trial) : rem_t;
        root_next[k][i] = {src_root[ROOT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      if (k == 0) begin
        ctl[k].degen <= ctl_in.degen;
        ctl[k].neg   <= ctl_in.neg;
      end else begin
        ctl[k].degen <= ctl[k-1].degen;
        ctl[k].neg   <= ctl[k-1].neg;
      end
      if (rst) begin
        ctl[k].valid <= 1'b0;
      end else if (k == 0) begin
        ctl[k].valid <= ctl_in.valid;
      end else begin
        ctl[k].valid <= ctl[k-1].valid;
      end
      for (int i = 0; i < 3; i++) begin
        rad[k][i]  <= rad_next[k][i];
        rem[k][i]  <= rem_next[k][i];
        root[k][i] <= root_next[k][i];
      end
    end
  end

  assign ctl_out = ctl[ROOT_W-1];
  always_comb begin
    for (int i = 0; i < 3; i++) root_out[i] = root[ROOT_W-1][i];
  end

  // root of an in-range quotient cannot pass twice the unit scale
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid && !ctl_out.degen |->
      root_out[0] <= ROOT_MAX && root_out[1] <= ROOT_MAX && root_out[2] <= ROOT_MAX)
    else $error("square root above bound");

endmodule

// File: hdl/triangle_unit_normal.sv
// triangle_unit_normal: top level, exact unit face normal of one triangle per word
// depends on tun_pkg, tun_front, tun_div, tun_sqrt
//
// One triangle word (three Q8.8 vertices) is taken on every clock where start is
// high; busy is tied low, so a new word may follow every cycle and the sustained
// rate is one word per cycle. Each word passes through six front stages (edges,
// cross product, squares, sum of squares), a 31-stage restoring divider that
// forms floor(c^2 * 2^30 / |c|^2) per component, a 16-stage square root, and
// one output register. Results come out in input order, each on the result
// ports for exactly one cycle with done high; there is no way to hold them, so
// the receiver must take every result as it appears.
// normal_x/y/z are signed Q1.14, rounded to nearest with ties away from zero;
// a triangle whose cross product is zero gives degenerate high and a zero normal.
module triangle_unit_normal (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tun_pkg::coord_t     p1_x,
  input  tun_pkg::coord_t     p1_y,
  input  tun_pkg::coord_t     p1_z,
  input  tun_pkg::coord_t     p2_x,
  input  tun_pkg::coord_t     p2_y,
  input  tun_pkg::coord_t     p2_z,
  input  tun_pkg::coord_t     p3_x,
  input  tun_pkg::coord_t     p3_y,
  input  tun_pkg::coord_t     p3_z,
  output logic                done,
  output tun_pkg::normal_t    normal_x,
  output tun_pkg::normal_t    normal_y,
  output tun_pkg::normal_t    normal_z,
  output logic                degenerate
);
  import tun_pkg::*;

  coord_t            pa [3];
  coord_t            pb [3];
  coord_t            pc [3];

  tun_ctl_t          ctl_front;
  logic [SQ_W-1:0]   sq [3];
  logic [SUM_W-1:0]  sum;
  tun_ctl_t          ctl_div;
  logic [QUO_W-1:0]  quo [3];
  tun_ctl_t          ctl_root;
  logic [ROOT_W-1:0] root [3];

  logic [ROOT_W:0]   m_sum [3];
  normal_t           comp [3];

  // pipeline never stalls
  assign busy = 1'b0;

  assign pa[0] = p1_x;
  assign pa[1] = p1_y;
  assign pa[2] = p1_z;
  assign pb[0] = p2_x;
  assign pb[1] = p2_y;
  assign pb[2] = p2_z;
  assign pc[0] = p3_x;
  assign pc[1] = p3_y;
  assign pc[2] = p3_z;

  tun_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .pa       (pa),
    .pb       (pb),
    .pc       (pc),
    .ctl_out  (ctl_front),
    .sq_out   (sq),
    .sum_out  (sum)
  );

  tun_div u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_front),
    .sq_in   (sq),
    .sum_in  (sum),
    .ctl_out (ctl_div),
    .quo_out (quo)
  );

  tun_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl_div),
    .quo_in   (quo),
    .ctl_out  (ctl_root),
    .root_out (root)
  );

  // largest odd y with y^2 <= q is the root or one below it;
  // the rounded magnitude is (y + 1) / 2, i.e. (root + 1) >> 1
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_sum[i] = {1'b0, root[i]} + (ROOT_W + 1)'(1);
      comp[i]  = ctl_root.neg[i] ? OUT_WIDTH'(-OUT_WIDTH'(m_sum[i][ROOT_W:1]))
                                 : OUT_WIDTH'(m_sum[i][ROOT_W:1]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_root.valid;
    end
    degenerate <= ctl_root.degen;
    normal_x   <= ctl_root.degen ? '0 : comp[0];
    normal_y   <= ctl_root.degen ? '0 : comp[1];
    normal_z   <= ctl_root.degen ? '0 : comp[2];
  end

  // a zero-length cross product must come out as a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("degenerate word with nonzero normal");

  // every component of a unit vector stays within one in Q1.14
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
             normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
             normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
    else $error("normal component out of unit range");

endmodule

// File: test/tun_checker.sv
// tun_checker: predicts and checks each triangle word of triangle_unit_normal
// depends on tun_pkg; instantiated by tb_top beside the block
module tun_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  tun_pkg::coord_t  p1_x, p1_y, p1_z,
  input  tun_pkg::coord_t  p2_x, p2_y, p2_z,
  input  tun_pkg::coord_t  p3_x, p3_y, p3_z,
  input  logic             done,
  input  tun_pkg::normal_t normal_x, normal_y, normal_z,
  input  logic             degenerate,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tun_pkg::*;

  typedef struct {
    normal_t nx;
    normal_t ny;
    normal_t nz;
    logic    degen;
  } normal_res_t;

  normal_res_t normal_queue[$];

  // largest m in 0..2^F with (2m-1)^2 * s <= c^2 * 2^(2F+2)
  function automatic longint unsigned round_unit(logic [191:0] cabs, logic [191:0] s);
    logic [191:0] rhs, t, lhs;
    longint unsigned lo, hi, mid;
    rhs = (cabs * cabs) << (2 * NORMAL_FRAC_BITS + 2);
    lo = 0;
    hi = 64'd1 << NORMAL_FRAC_BITS;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 192'(2 * mid - 1);
      lhs = t * t * s;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic normal_res_t face_normal(coord_t ax, ay, az, bx, by, bz, dx, dy, dz);
    longint e1x, e1y, e1z, e2x, e2y, e2z;
    longint c[3];
    logic [191:0] cabs[3];
    logic [191:0] s;
    longint unsigned m;
    normal_t n[3];
    normal_res_t r;
    e1x = longint'(bx) - longint'(ax);
    e1y = longint'(by) - longint'(ay);
    e1z = longint'(bz) - longint'(az);
    e2x = longint'(dx) - longint'(ax);
    e2y = longint'(dy) - longint'(ay);
    e2z = longint'(dz) - longint'(az);
    c[0] = e1y * e2z - e2y * e1z;
    c[1] = e2x * e1z - e1x * e2z;
    c[2] = e1x * e2y - e2x * e1y;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      cabs[i] = 192'(c[i] < 0 ? -c[i] : c[i]);
      s = s + cabs[i] * cabs[i];
    end
    r.degen = (s == 0);
    for (int i = 0; i < 3; i++) begin
      if (r.degen) n[i] = '0;
      else begin
        m = round_unit(cabs[i], s);
        // wraps to the output width
        n[i] = normal_t'(c[i] < 0 ? -longint'(m) : longint'(m));
      end
    end
    r.nx = n[0];
    r.ny = n[1];
    r.nz = n[2];
    return r;
  endfunction

  assign pending = normal_queue.size();

  always @(posedge clk) begin
    normal_res_t want;
    if (!rst && start && !busy)
      normal_queue.push_back(face_normal(p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                                         p3_x, p3_y, p3_z));
    if (!rst && done) begin
      if (normal_queue.size() == 0) begin
        $error("normal word with nothing expected");
        fail_count = fail_count + 1;
      end else begin
        want = normal_queue.pop_front();
        if (normal_x !== want.nx) begin
          $error("normal_x expected %0d actual %0d", want.nx, normal_x);
          fail_count = fail_count + 1;
        end
        if (normal_y !== want.ny) begin
          $error("normal_y expected %0d actual %0d", want.ny, normal_y);
          fail_count = fail_count + 1;
        end
        if (normal_z !== want.nz) begin
          $error("normal_z expected %0d actual %0d", want.nz, normal_z);
          fail_count = fail_count + 1;
        end
        if (degenerate !== want.degen) begin
          $error("degenerate expected %0b actual %0b", want.degen, degenerate);
          fail_count = fail_count + 1;
        end
      end
    end
  end

endmodule

// File: test/tb_top.sv
// tb_top: stimulus and verdict for triangle_unit_normal
// depends on tun_pkg, the block and tun_checker, which predicts and compares
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tun_pkg::*;

  localparam int LATENCY     = 54;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_WORDS  = 1600;

  logic    clk, rst, start, busy, done, degenerate;
  coord_t  p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
  normal_t normal_x, normal_y, normal_z;
  int      fail_count, pending;
  int      cycle_count = 0;
  int      idle_pct;

  triangle_unit_normal i_dut (.*);

  tun_checker i_checker (.*);

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // hard stop if the pipeline hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // random gaps before a word; start goes low only on a real gap
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one triangle word and hold it until taken
  task automatic send_tri(coord_t ax, ay, az, bx, by, bz, cx, cy, cz);
    sender_gap();
    start <= 1'b1;
    p1_x <= ax; p1_y <= ay; p1_z <= az;
    p2_x <= bx; p2_y <= by; p2_z <= bz;
    p3_x <= cx; p3_y <= cy; p3_z <= cz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // small coordinates make exact axes, ties and short edges more likely
  function automatic coord_t rand_small();
    return coord_t'($signed($urandom_range(16)) - 8);
  endfunction

  // one random word: mostly general triangles, some small, some degenerate
  task automatic send_random();
    coord_t a[3], b[3], c[3];
    int kind, k;
    kind = $urandom_range(9);
    k = $signed($urandom_range(6)) - 3;
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_coord();
      b[i] = rand_coord();
      c[i] = rand_coord();
      if (kind >= 5 && kind <= 6) begin
        b[i] = a[i] + rand_small();
        c[i] = a[i] + rand_small();
      end
    end
    if (kind == 7) begin
      // collinear: third vertex on the line through the first two
      for (int i = 0; i < 3; i++) begin
        b[i] = a[i] + rand_small();
        c[i] = a[i] + coord_t'(k * (b[i] - a[i]));
      end
    end else if (kind == 8) begin
      // two coincident vertices
      b = a;
    end
    send_tri(a[0], a[1], a[2], b[0], b[1], b[2], c[0], c[1], c[2]);
  endtask

  initial begin
    idle_pct    = 0;
    rst   = 1'b1;
    start = 1'b0;
    {p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z} = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: degenerate cases, axis normals, extremes
    send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_tri(100, 200, 300, 100, 200, 300, -5, 7, 9);
    send_tri(0, 0, 0, 1, 1, 1, 2, 2, 2);
    send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_tri(0, 0, 0, 0, 256, 0, 256, 0, 0);
    send_tri(0, 0, 0, 0, 1, 0, 0, 0, 1);
    send_tri(0, 0, 0, 0, 0, 1, 1, 0, 0);
    send_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_tri(0, 0, 0, 1, 1, 0, 0, 1, 1);
    send_tri(0, 0, 0, 3, 0, 0, 0, 4, 1);
    send_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
    send_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767);
    send_tri(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);
    send_tri(-32768, 0, 0, 32767, 0, 0, 0, 32767, 32767);
    send_tri(-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768);
    send_tri(-32768, 32767, -1, 32767, -32768, 0, -1, 0, 32767);
    send_tri(0, 0, 0, 32767, 1, 0, 1, 32767, 0);
    send_tri(0, 0, 0, 1, 2, 3, 4, 5, 6);

    // hold off until the pipeline has drained
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // sender gaps: 27 percent, then 60, then none
    idle_pct = 27;
    repeat (RAND_WORDS / 3) send_random();
    idle_pct = 60;
    repeat (RAND_WORDS / 3) send_random();
    idle_pct = 0;
    repeat (RAND_WORDS - 2 * (RAND_WORDS / 3)) send_random();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
